@@ design/sha1_pkg.sv @@
// shared types, constants and helpers for the sha-1 hasher
package sha1_pkg;

    localparam int unsigned FILL_W   = 6;
    localparam int unsigned ROUND_W  = 7;
    localparam int unsigned IDX_W    = 3;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [ROUND_W-1:0] SCHED_LEN  = 7'd16;
    localparam logic [ROUND_W-1:0] PHASE1_END = 7'd20;
    localparam logic [ROUND_W-1:0] PHASE2_END = 7'd40;
    localparam logic [ROUND_W-1:0] PHASE3_END = 7'd60;

    localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
    localparam logic [FILL_W-1:0] LEN_POS   = 6'd56;
    localparam logic [IDX_W-1:0]  LAST_IDX  = 3'd4;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_work;

    localparam t_work H_INIT = '{
        a: 32'h67452301,
        b: 32'hEFCDAB89,
        c: 32'h98BADCFE,
        d: 32'h10325476,
        e: 32'hC3D2E1F0
    };

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_PAD_ONE  = 7'b0000010,
        ST_PAD_ZERO = 7'b0000100,
        ST_PAD_LEN  = 7'b0001000,
        ST_ROUND    = 7'b0010000,
        ST_FOLD     = 7'b0100000,
        ST_OUT      = 7'b1000000
    } t_state;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

endpackage

@@ design/sha1_if.sv @@
// valid/ready channels for message bytes in and digest words out
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

@@ design/sha1_round.sv @@
// one sha-1 round: boolean function, round constant and working-word update
module sha1_round (
    input  sha1_pkg::t_work               i_work,
    input  logic [31:0]                   i_w,
    input  logic [sha1_pkg::ROUND_W-1:0]  i_round,
    output sha1_pkg::t_work               o_work
);

    logic [31:0] fn;
    logic [31:0] kc;

    always_comb begin
        priority if (i_round < sha1_pkg::PHASE1_END) begin
            fn = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            kc = sha1_pkg::K0;
        end else if (i_round < sha1_pkg::PHASE2_END) begin
            fn = i_work.b ^ i_work.c ^ i_work.d;
            kc = sha1_pkg::K1;
        end else if (i_round < sha1_pkg::PHASE3_END) begin
            fn = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            kc = sha1_pkg::K2;
        end else begin
            fn = i_work.b ^ i_work.c ^ i_work.d;
            kc = sha1_pkg::K3;
        end
    end

    always_comb begin
        o_work.a = sha1_pkg::rotl(i_work.a, 5) + fn + i_work.e + kc + i_w;
        o_work.b = i_work.a;
        o_work.c = sha1_pkg::rotl(i_work.b, 30);
        o_work.d = i_work.c;
        o_work.e = i_work.d;
    end

endmodule

@@ design/sha1_hash.sv @@
// streaming sha-1 hasher: byte intake, padding sequencer and iterative round unit
// append: bytes are taken only while idle; the 64th byte of a block runs the rounds and a fold
// finish: pads with 0x80, zero bytes and the bit length, with one or two block compressions,
//   then five digest words leave on consecutive transfers as the sink takes them
// synchronous active-low reset restores the initial hash values and clears the counters
module sha1_hash (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sha1_in_if.sink           i_in,
    sha1_out_if.source        o_out
);

    sha1_pkg::t_state               r_state, n_state;
    sha1_pkg::t_state               r_after, n_after;
    sha1_pkg::t_work                r_h, n_h;
    sha1_pkg::t_work                r_work, n_work;
    sha1_pkg::t_work                round_out;
    logic [sha1_pkg::FILL_W-1:0]    r_fill, n_fill;
    logic [63:0]                    r_bits, n_bits;
    logic [sha1_pkg::ROUND_W-1:0]   r_round, n_round;
    logic [sha1_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic [23:0]                    r_acc, n_acc;
    logic [15:0][31:0]              r_win, n_win;

    logic        in_fire;
    logic        out_fire;
    logic        put_en;
    logic [7:0]  put_byte;
    logic [7:0]  len_byte;
    logic [31:0] w_t;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    assign i_in.ready        = (r_state == sha1_pkg::ST_IDLE);
    assign o_out.valid       = (r_state == sha1_pkg::ST_OUT);
    assign o_out.digest_word = r_h.a;
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = (r_idx == sha1_pkg::LAST_IDX);

    // length field goes out big-endian, byte chosen by position within the last eight
    assign len_byte = 8'(r_bits >> {~r_fill[2:0], 3'b000});

    // schedule window: first sixteen rounds recirculate the loaded words
    assign w_t = (r_round < sha1_pkg::SCHED_LEN) ? r_win[0] :
                 sha1_pkg::rotl(r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0], 1);

    sha1_round u_round (
        .i_work  (r_work),
        .i_w     (w_t),
        .i_round (r_round),
        .o_work  (round_out)
    );

    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_h      = r_h;
        n_work   = r_work;
        n_fill   = r_fill;
        n_bits   = r_bits;
        n_round  = r_round;
        n_idx    = r_idx;
        n_acc    = r_acc;
        n_win    = r_win;
        put_en   = 1'b0;
        put_byte = sha1_pkg::ZERO_BYTE;

        unique case (r_state)
            sha1_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.op == sha1_pkg::OP_FINISH) begin
                        n_state = sha1_pkg::ST_PAD_ONE;
                    end else begin
                        put_en   = 1'b1;
                        put_byte = i_in.data_byte;
                        n_bits   = r_bits + sha1_pkg::BITS_PER_BYTE;
                        n_after  = sha1_pkg::ST_IDLE;
                    end
                end
            end
            sha1_pkg::ST_PAD_ONE: begin
                put_en   = 1'b1;
                put_byte = sha1_pkg::PAD_BYTE;
                n_after  = sha1_pkg::ST_PAD_ZERO;
                n_state  = sha1_pkg::ST_PAD_ZERO;
            end
            sha1_pkg::ST_PAD_ZERO: begin
                if (r_fill == sha1_pkg::LEN_POS) begin
                    n_state = sha1_pkg::ST_PAD_LEN;
                end else begin
                    put_en   = 1'b1;
                    put_byte = sha1_pkg::ZERO_BYTE;
                    n_after  = sha1_pkg::ST_PAD_ZERO;
                end
            end
            sha1_pkg::ST_PAD_LEN: begin
                put_en   = 1'b1;
                put_byte = len_byte;
                n_after  = sha1_pkg::ST_OUT;
            end
            sha1_pkg::ST_ROUND: begin
                n_work  = round_out;
                n_win   = {w_t, r_win[15:1]};
                n_round = r_round + 7'd1;
                if (r_round == sha1_pkg::LAST_ROUND) begin
                    n_state = sha1_pkg::ST_FOLD;
                end
            end
            sha1_pkg::ST_FOLD: begin
                n_h.a   = r_h.a + r_work.a;
                n_h.b   = r_h.b + r_work.b;
                n_h.c   = r_h.c + r_work.c;
                n_h.d   = r_h.d + r_work.d;
                n_h.e   = r_h.e + r_work.e;
                n_idx   = '0;
                n_state = r_after;
            end
            sha1_pkg::ST_OUT: begin
                if (out_fire) begin
                    if (r_idx == sha1_pkg::LAST_IDX) begin
                        n_h     = sha1_pkg::H_INIT;
                        n_fill  = '0;
                        n_bits  = '0;
                        n_state = sha1_pkg::ST_IDLE;
                    end else begin
                        // next word moves to the head of the chain
                        n_h   = {r_h.b, r_h.c, r_h.d, r_h.e, r_h.a};
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = sha1_pkg::ST_IDLE;
            end
        endcase

        // shared byte intake: packs big-endian words into the schedule window
        if (put_en) begin
            n_acc  = {r_acc[15:0], put_byte};
            n_fill = r_fill + 6'd1;
            if (r_fill[1:0] == 2'b11) begin
                n_win = {{r_acc, put_byte}, r_win[15:1]};
            end
            if (r_fill == sha1_pkg::FILL_LAST) begin
                n_state = sha1_pkg::ST_ROUND;
                n_round = '0;
                n_work  = r_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1_pkg::ST_IDLE;
            r_after <= sha1_pkg::ST_IDLE;
            r_h     <= sha1_pkg::H_INIT;
            r_fill  <= '0;
            r_bits  <= '0;
            r_round <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_h     <= n_h;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
            r_round <= n_round;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_acc  <= n_acc;
        r_win  <= n_win;
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_idx <= sha1_pkg::LAST_IDX))
        else $error("digest word index out of range");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_out.last_word) |=>
            (r_state == sha1_pkg::ST_IDLE) && (r_fill == '0) && (r_bits == '0)
            && (r_h == sha1_pkg::H_INIT))
        else $error("state not restored after final digest word");

    a_round_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == sha1_pkg::ST_ROUND) && (r_round == '0)) |-> (r_fill == '0))
        else $error("compression started without a full block");

    a_finish_pads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in.op == sha1_pkg::OP_FINISH)) |=>
            (r_state == sha1_pkg::ST_PAD_ONE) && $stable(r_bits))
        else $error("finish transfer did not start padding");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha1_pkg::ST_ROUND) |-> (r_round <= sha1_pkg::LAST_ROUND))
        else $error("round counter overran");

endmodule
